// ===== sv/u8d_pkg.sv =====
package u8d_pkg;

  // Field widths of the byte stream and of the decoded result.
  localparam int DataW = 8;
  localparam int CpW   = 31;
  localparam int PendW = 3;
  localparam int PayW  = 6;

  // Byte classes: continuation bytes are 10xxxxxx, leads start at C0.
  localparam logic [DataW-1:0] ContMask  = 8'hC0;
  localparam logic [DataW-1:0] ContTag   = 8'h80;
  localparam logic [DataW-1:0] Lead2Min  = 8'hC0;
  localparam logic [DataW-1:0] Lead3Min  = 8'hE0;
  localparam logic [DataW-1:0] Lead4Min  = 8'hF0;
  localparam logic [DataW-1:0] Lead5Min  = 8'hF8;
  localparam logic [DataW-1:0] Lead6Min  = 8'hFC;

  // Payload masks of the lead bytes and of a continuation byte.
  localparam logic [DataW-1:0] Lead2Mask = 8'h1F;
  localparam logic [DataW-1:0] Lead3Mask = 8'h0F;
  localparam logic [DataW-1:0] Lead4Mask = 8'h07;
  localparam logic [DataW-1:0] Lead5Mask = 8'h03;
  localparam logic [DataW-1:0] Lead6Mask = 8'h01;
  localparam logic [DataW-1:0] PayMask   = 8'h3F;

  // Trailing byte counts opened by each lead class.
  localparam logic [PendW-1:0] Trail2 = 3'd1;
  localparam logic [PendW-1:0] Trail3 = 3'd2;
  localparam logic [PendW-1:0] Trail4 = 3'd3;
  localparam logic [PendW-1:0] Trail5 = 3'd4;
  localparam logic [PendW-1:0] Trail6 = 3'd5;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [CpW-1:0]   part;
  } dec_state_t;

  // Outcome of decoding one byte.
  typedef struct packed {
    logic           emit;
    logic           has_char;
    logic           last;
    logic [CpW-1:0] cp;
  } step_res_t;

endpackage

// ===== sv/utf8_to_code_point_decoder_core.sv =====
// Channel  Direction  tdata                    tuser      tlast
// in_      input      [7:0] data_byte          -          end_of_text
// out_     output     [30:0] code_point        has_char   is_last
//
// One byte is taken every cycle unless a stalled output holds the input register.
// The byte sits in an input register, is decoded against the sequence state,
// and the result lands in the output register as the byte leaves the input register.
// A stalled output holds only bytes that produce a result; others pass on.
// Reset (rst_n low, synchronous) empties both registers and closes any sequence.
module utf8_to_code_point_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [u8d_pkg::DataW-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [u8d_pkg::CpW:0]         out_tdata,  // [30:0] code_point, [31] zero
  output logic                          out_tuser,  // [0] has_char
  output logic                          out_tlast
);
  import u8d_pkg::*;

  logic              s1_vld_r;
  logic [DataW-1:0]  s1_byte_r;
  logic              s1_last_r;
  dec_state_t        st_r;
  dec_state_t        st_nxt;
  step_res_t         res;
  logic              out_vld_r;
  logic [CpW-1:0]    out_cp_r;
  logic              out_has_r;
  logic              out_last_r;
  logic              out_free;
  logic              s1_go;

  // Handshake: the input register moves on when its result has a place.
  assign out_free  = !out_vld_r || out_tready;
  assign s1_go     = s1_vld_r && (!res.emit || out_free);
  assign in_tready = !s1_vld_r || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Decode of the registered byte against the sequence state.
  u8d_step u_step (
    .cur         (st_r),
    .data_byte   (s1_byte_r),
    .end_of_text (s1_last_r),
    .nxt         (st_nxt),
    .res         (res)
  );

  // Sequence state advances once per byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_cp_r   <= res.cp;
      out_has_r  <= res.has_char;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_cp_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  // An end byte always closes any open sequence.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (st_r.pend == '0))
    else $error("sequence still open after end of text");

  // With no sequence open, no partial bits may remain.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.pend == '0) |-> (st_r.part == '0))
    else $error("partial value left without open sequence");

  // A result without a character only comes from an end byte, with zero data.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && (out_tdata == '0)))
    else $error("empty result not marked last or not zero");

  // At most five trailing bytes are ever pending.
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.pend <= Trail6))
    else $error("pending count out of range");

endmodule

// ===== sv/u8d_step.sv =====
module u8d_step (
  input  u8d_pkg::dec_state_t           cur,
  input  logic [u8d_pkg::DataW-1:0]     data_byte,
  input  logic                          end_of_text,
  output u8d_pkg::dec_state_t           nxt,
  output u8d_pkg::step_res_t            res
);
  import u8d_pkg::*;

  logic                 is_cont;
  logic [CpW-1:0]       part_sh;
  logic [PendW-1:0]     pend_dec;
  logic                 done;
  logic [CpW-1:0]       cp;
  logic [DataW-1:0]     lead_pay;

  // A continuation byte extends an open sequence by six bits.
  assign is_cont  = (cur.pend != '0) && ((data_byte & ContMask) == ContTag);
  assign part_sh  = {cur.part[CpW-PayW-1:0], data_byte[PayW-1:0]};
  assign pend_dec = cur.pend - PendW'(1);

  always_comb begin
    done     = 1'b0;
    cp       = '0;
    nxt      = '0;
    lead_pay = '0;
    if (is_cont) begin
      if (pend_dec == '0) begin
        done = 1'b1;
        cp   = part_sh;
      end else begin
        nxt.pend = pend_dec;
        nxt.part = part_sh;
      end
    end else begin
      // No sequence open, or a broken one: the byte is decoded afresh.
      priority if (data_byte < Lead2Min) begin
        done = 1'b1;
        cp   = {{(CpW-DataW){1'b0}}, data_byte};
      end else if (data_byte < Lead3Min) begin
        nxt.pend = Trail2;
        lead_pay = data_byte & Lead2Mask;
      end else if (data_byte < Lead4Min) begin
        nxt.pend = Trail3;
        lead_pay = data_byte & Lead3Mask;
      end else if (data_byte < Lead5Min) begin
        nxt.pend = Trail4;
        lead_pay = data_byte & Lead4Mask;
      end else if (data_byte < Lead6Min) begin
        nxt.pend = Trail5;
        lead_pay = data_byte & Lead5Mask;
      end else begin
        nxt.pend = Trail6;
        lead_pay = data_byte & Lead6Mask;
      end
      nxt.part = {{(CpW-DataW){1'b0}}, lead_pay};
    end
    // The end of a string always leaves the decoder in its reset state.
    if (end_of_text) begin
      nxt = '0;
    end
  end

  // A result is given for a finished character or for the end of a string.
  assign res.emit     = done || end_of_text;
  assign res.has_char = done;
  assign res.last     = end_of_text;
  assign res.cp       = done ? cp : '0;

endmodule

// ===== dv/u8d_stream_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the decoder, keeps its own decode state and the
// results still owed, and compares every output transfer against them.
module u8d_stream_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [u8d_pkg::DataW-1:0] in_tdata,
  input  logic                      in_tlast,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [u8d_pkg::CpW:0]     out_tdata,
  input  logic                      out_tuser,
  input  logic                      out_tlast,
  output int                        err_count,
  output int                        owed_count,
  output int                        result_count,
  output int                        char_count
);
  import u8d_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           has_char;
    logic           last;
  } cp_result_t;

  // Decode state of the model side.
  logic [PendW-1:0] trail_left;
  logic [CpW-1:0]   cp_accum;
  cp_result_t       owed_q[$];

  initial begin
    err_count    = 0;
    owed_count   = 0;
    result_count = 0;
    char_count   = 0;
    trail_left   = '0;
    cp_accum     = '0;
  end

  // Advance the decode state by one byte and queue the result it owes, if any.
  function automatic void decode_byte(input logic [DataW-1:0] b, input logic eot);
    logic           done;
    logic [CpW-1:0] cp;
    cp_result_t     res;
    done = 1'b0;
    cp   = '0;
    if (trail_left != '0 && (b & ContMask) == ContTag) begin
      cp_accum   = {cp_accum[CpW-PayW-1:0], b[PayW-1:0]};
      trail_left = trail_left - PendW'(1);
      if (trail_left == '0) begin
        cp       = cp_accum;
        cp_accum = '0;
        done     = 1'b1;
      end
    end else begin
      // No sequence open, or it was broken: start over on this byte.
      trail_left = '0;
      cp_accum   = '0;
      if (b < Lead2Min) begin
        cp   = CpW'(b);
        done = 1'b1;
      end else if (b < Lead3Min) begin
        trail_left = Trail2;
        cp_accum   = CpW'(b & Lead2Mask);
      end else if (b < Lead4Min) begin
        trail_left = Trail3;
        cp_accum   = CpW'(b & Lead3Mask);
      end else if (b < Lead5Min) begin
        trail_left = Trail4;
        cp_accum   = CpW'(b & Lead4Mask);
      end else if (b < Lead6Min) begin
        trail_left = Trail5;
        cp_accum   = CpW'(b & Lead5Mask);
      end else begin
        trail_left = Trail6;
        cp_accum   = CpW'(b & Lead6Mask);
      end
    end
    // The end of a string always closes any open sequence.
    if (eot) begin
      trail_left = '0;
      cp_accum   = '0;
    end
    if (done || eot) begin
      res.cp       = done ? cp : '0;
      res.has_char = done;
      res.last     = eot;
      owed_q.push_back(res);
    end
  endfunction

  function automatic void check_field(input string name, input logic [CpW:0] exp_val,
                                      input logic [CpW:0] act_val);
    if (exp_val !== act_val) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               exp_val, act_val);
    end
  endfunction

  // Output transfers are checked before the input of the same edge is taken in.
  always @(posedge clk) begin
    cp_result_t res;
    if (!rst_n) begin
      trail_left = '0;
      cp_accum   = '0;
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        if (owed_q.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing owed, actual cp 0x%0h char %0b last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          res = owed_q.pop_front();
          if (res.has_char) char_count++;
          check_field("code_point", {1'b0, res.cp}, {1'b0, out_tdata[CpW-1:0]});
          check_field("pad bit", '0, (CpW+1)'(out_tdata[CpW]));
          check_field("has_char", (CpW+1)'(res.has_char), (CpW+1)'(out_tuser));
          check_field("is_last", (CpW+1)'(res.last), (CpW+1)'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    owed_count = owed_q.size();
  end

endmodule

// ===== dv/utf8_to_code_point_decoder_core_tb.sv =====
`timescale 1ns / 100ps

module utf8_to_code_point_decoder_core_tb;
  import u8d_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [DataW-1:0] in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [CpW:0]     out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  int err_count;
  int owed_count;
  int result_count;
  int char_count;
  int byte_count;
  int text_count;
  logic steady;

  logic [DataW-1:0] text_q[$];

  utf8_to_code_point_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  u8d_stream_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .err_count    (err_count),
    .owed_count   (owed_count),
    .result_count (result_count),
    .char_count   (char_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long; none in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sink side: alternate runs of ready with stalls of random length.
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Send the bytes in text_q, with the end flag on the final one.
  task automatic send_text();
    int gap;
    for (int i = 0; i < text_q.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = text_q[i];
      in_tlast  = (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
      byte_count++;
    end
    text_count++;
  endtask

  // Append one character of a random length class with random payload.
  task automatic append_char();
    int r;
    int trail;
    logic [DataW-1:0] lead;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      lead  = DataW'($urandom_range(8'h00, 8'h7F));
      trail = 0;
    end else if (r < 34) begin
      lead  = DataW'($urandom_range(8'h80, 8'hBF));
      trail = 0;
    end else if (r < 50) begin
      lead  = DataW'($urandom_range(8'hC0, 8'hDF));
      trail = 1;
    end else if (r < 64) begin
      lead  = DataW'($urandom_range(8'hE0, 8'hEF));
      trail = 2;
    end else if (r < 77) begin
      lead  = DataW'($urandom_range(8'hF0, 8'hF7));
      trail = 3;
    end else if (r < 88) begin
      lead  = DataW'($urandom_range(8'hF8, 8'hFB));
      trail = 4;
    end else begin
      lead  = DataW'($urandom_range(8'hFC, 8'hFF));
      trail = 5;
    end
    text_q.push_back(lead);
    for (int i = 0; i < trail; i++) text_q.push_back(ContTag | DataW'($urandom_range(0, 63)));
  endtask

  // Mostly well-formed strings; some get a byte replaced, dropped or inserted, or are cut off.
  task automatic build_text();
    int pos;
    int r;
    text_q.delete();
    repeat ($urandom_range(1, 10)) append_char();
    r = $urandom_range(0, 99);
    pos = $urandom_range(0, text_q.size() - 1);
    if (r < 8) begin
      text_q[pos] = DataW'($urandom_range(0, 255));
    end else if (r < 14 && text_q.size() > 1) begin
      text_q.delete(pos);
    end else if (r < 20) begin
      text_q.insert(pos, DataW'($urandom_range(0, 255)));
    end else if (r < 26) begin
      text_q.push_back(DataW'($urandom_range(8'hC0, 8'hFF)));
    end
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    steady     = 1'b0;
    byte_count = 0;
    text_count = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero and top ASCII, stray continuations, two-, three- and four-byte
    // sequences and one with the all-ones six-byte lead, a broken sequence, a string
    // cut short inside a sequence, and a string ending on a lone lead.
    text_q = '{8'h00, 8'h7F};
    send_text();
    text_q = '{8'h80, 8'hBF, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hC3, 8'h41};
    send_text();
    text_q = '{8'hE2, 8'h82};
    send_text();
    text_q = '{8'hFC};
    send_text();

    // Random strings, with occasional stretches of back-to-back traffic.
    while (byte_count < 745) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      build_text();
      send_text();
    end
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    steady    = 1'b0;

    while (owed_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them characters.",
             byte_count, text_count, result_count, char_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still owed.", owed_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
